### design/ttm_pkg.sv
// ---------------------------------------------------------------------------
// ttm_pkg
// Shared types and codes for the tablet to multitouch event translator.
// ---------------------------------------------------------------------------
package ttm_pkg;

    // largest tracking id before wrap
    localparam int unsigned TRACK_ID_MAX = 65535;
    localparam int unsigned TRACK_W      = 16;

    // command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // event sequencer step counter
    localparam int unsigned STEP_W = 4;

    // event types
    localparam logic [15:0] EVT_SYN = 16'h0000;
    localparam logic [15:0] EVT_KEY = 16'h0001;
    localparam logic [15:0] EVT_ABS = 16'h0003;

    // sync and absolute codes
    localparam logic [15:0] SYNC_REPORT   = 16'h0000;
    localparam logic [15:0] CODE_ABS_X    = 16'h0000;
    localparam logic [15:0] CODE_ABS_Y    = 16'h0001;
    localparam logic [15:0] CODE_MT_SLOT  = 16'h002F;
    localparam logic [15:0] CODE_MT_POS_X = 16'h0035;
    localparam logic [15:0] CODE_MT_POS_Y = 16'h0036;
    localparam logic [15:0] CODE_MT_TOOL  = 16'h0037;
    localparam logic [15:0] CODE_MT_TRACK = 16'h0039;
    localparam logic [15:0] CODE_MT_DIST  = 16'h003B;
    localparam logic [31:0] TOOL_PEN      = 32'd2;
    localparam logic [31:0] TRACK_RELEASE = 32'hFFFF_FFFF;

    // button and key codes
    localparam logic [15:0] B_LEFT      = 16'h0110;
    localparam logic [15:0] B_RIGHT     = 16'h0111;
    localparam logic [15:0] B_MIDDLE    = 16'h0112;
    localparam logic [15:0] B_TOUCH     = 16'h014A;
    localparam logic [15:0] B_GEAR_DOWN = 16'h0150;
    localparam logic [15:0] B_GEAR_UP   = 16'h0151;
    localparam logic [15:0] K_UP        = 16'd103;
    localparam logic [15:0] K_DOWN      = 16'd108;
    localparam logic [15:0] K_MENU      = 16'd139;
    localparam logic [15:0] K_BACK      = 16'd158;

    // input beat
    typedef struct packed {
        logic [15:0]        event_type;
        logic [15:0]        event_code;
        logic signed [31:0] event_value;
    } evt_t;

    // output beat
    typedef struct packed {
        logic [15:0]        out_type;
        logic [15:0]        out_code;
        logic signed [31:0] out_value;
        logic               last_of_run;
    } res_t;

    // what the back end has to emit for one input
    typedef enum logic [2:0] {
        CMD_KEY,
        CMD_PAIR,
        CMD_FRAME_ON,
        CMD_FRAME_OFF,
        CMD_SYNC
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [15:0]         key_code;
        logic [31:0]         key_value;
        logic [TRACK_W-1:0]  track;
        logic [31:0]         pos_x;
        logic [31:0]         pos_y;
        logic                contact;
    } cmd_t;

endpackage

### design/ttm_front.sv
// ---------------------------------------------------------------------------
// ttm_front
// Accepts input beats, keeps pointer state and turns the inputs that need
// output into commands for the event sequencer.
// ---------------------------------------------------------------------------
module ttm_front
    import ttm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data,
    input  logic evt_valid,
    output logic evt_ready,
    input  evt_t evt,
    output logic cmd_push,
    output cmd_t cmd,
    input  logic q_full
);

    logic               hover_reg;
    logic               active_reg, active_next;
    logic               contact_reg, contact_next;
    logic               prev_reg, prev_next;
    logic               sync_reg, sync_next;
    logic               frame_reg, frame_next;
    logic [TRACK_W-1:0] track_reg, track_next;
    logic [31:0]        pos_x_reg, pos_x_next;
    logic [31:0]        pos_y_reg, pos_y_next;
    logic [TRACK_W:0]   track_inc;
    logic               fire;
    logic               accept;
    logic               pressed;

    assign cfg_ready = 1'b1;
    assign evt_ready = !q_full;
    assign accept    = evt_valid && evt_ready;
    assign pressed   = (evt.event_value != 32'sd0);
    assign track_inc = {1'b0, track_reg} + {{TRACK_W{1'b0}}, 1'b1};

    // classify the input and compute next state
    always_comb
    begin
        active_next  = hover_reg ? 1'b1 : active_reg;
        contact_next = hover_reg ? contact_reg : 1'b1;
        prev_next    = prev_reg;
        sync_next    = sync_reg;
        frame_next   = frame_reg;
        track_next   = track_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        fire         = 1'b0;
        cmd_push     = 1'b0;
        cmd.kind      = CMD_SYNC;
        cmd.key_code  = 16'd0;
        cmd.key_value = evt.event_value;
        cmd.track     = track_reg;
        cmd.pos_x     = pos_x_reg;
        cmd.pos_y     = pos_y_reg;
        cmd.contact   = contact_next;
        case (evt.event_type)
            EVT_KEY:
            begin
                case (evt.event_code)
                    B_LEFT:
                    begin
                        if (hover_reg)
                        begin
                            contact_next = pressed;
                        end
                        else
                        begin
                            active_next = pressed;
                        end
                        frame_next = 1'b1;
                    end
                    B_MIDDLE:
                    begin
                        cmd.kind     = CMD_KEY;
                        cmd.key_code = K_MENU;
                        cmd_push     = 1'b1;
                        sync_next    = 1'b1;
                    end
                    B_RIGHT:
                    begin
                        cmd.kind     = CMD_KEY;
                        cmd.key_code = K_BACK;
                        cmd_push     = 1'b1;
                        sync_next    = 1'b1;
                    end
                    B_GEAR_DOWN:
                    begin
                        cmd.kind     = CMD_PAIR;
                        cmd.key_code = K_DOWN;
                        cmd_push     = 1'b1;
                        sync_next    = 1'b1;
                    end
                    B_GEAR_UP:
                    begin
                        cmd.kind     = CMD_PAIR;
                        cmd.key_code = K_UP;
                        cmd_push     = 1'b1;
                        sync_next    = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            EVT_ABS:
            begin
                if (evt.event_code == CODE_ABS_X)
                begin
                    pos_x_next = evt.event_value;
                    frame_next = 1'b1;
                end
                else if (evt.event_code == CODE_ABS_Y)
                begin
                    pos_y_next = evt.event_value;
                    frame_next = 1'b1;
                end
            end
            EVT_SYN:
            begin
                if (evt.event_code == SYNC_REPORT)
                begin
                    fire = frame_reg && (prev_reg || active_next);
                    if (fire)
                    begin
                        cmd.kind   = active_next ? CMD_FRAME_ON : CMD_FRAME_OFF;
                        frame_next = 1'b0;
                        prev_next  = active_next;
                        if (!active_next)
                        begin
                            // tracking id advances after a release, wraps past max
                            if (track_inc > (TRACK_W + 1)'(TRACK_ID_MAX))
                            begin
                                track_next = '0;
                            end
                            else
                            begin
                                track_next = track_inc[TRACK_W-1:0];
                            end
                        end
                    end
                    cmd_push  = fire || sync_reg;
                    sync_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        cmd_push = cmd_push && accept;
    end

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hover_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            hover_reg <= cfg_data;
        end
    end

    // pointer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            contact_reg <= 1'b0;
            prev_reg    <= 1'b0;
            sync_reg    <= 1'b0;
            frame_reg   <= 1'b0;
            track_reg   <= '0;
            pos_x_reg   <= 32'd0;
            pos_y_reg   <= 32'd0;
        end
        else if (accept)
        begin
            active_reg  <= active_next;
            contact_reg <= contact_next;
            prev_reg    <= prev_next;
            sync_reg    <= sync_next;
            frame_reg   <= frame_next;
            track_reg   <= track_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
        end
    end

endmodule

### design/ttm_queue.sv
// ---------------------------------------------------------------------------
// ttm_queue
// Short command queue between the front end and the event sequencer.
// ---------------------------------------------------------------------------
module ttm_queue
    import ttm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### design/ttm_back.sv
// ---------------------------------------------------------------------------
// ttm_back
// Event sequencer: walks the events of the head command, one per cycle
// while the output is not stalled, into the output register.
// ---------------------------------------------------------------------------
module ttm_back
    import ttm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t head,
    input  logic empty,
    output logic pop,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    logic [STEP_W-1:0] step_reg;
    logic              res_valid_reg;
    res_t              res_reg;
    res_t              ev;
    logic              take;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign take      = !empty && (!res_valid_reg || res_ready);
    assign pop       = take && ev.last_of_run;

    // event for the current step of the head command
    always_comb
    begin
        ev.out_type    = EVT_SYN;
        ev.out_code    = SYNC_REPORT;
        ev.out_value   = 32'sd0;
        ev.last_of_run = 1'b1;
        case (head.kind)
            CMD_KEY:
            begin
                ev.out_type  = EVT_KEY;
                ev.out_code  = head.key_code;
                ev.out_value = head.key_value;
            end
            CMD_PAIR:
            begin
                ev.out_type    = EVT_KEY;
                ev.out_code    = head.key_code;
                ev.out_value   = (step_reg == '0) ? 32'sd1 : 32'sd0;
                ev.last_of_run = (step_reg != '0);
            end
            CMD_FRAME_ON:
            begin
                ev.last_of_run = 1'b0;
                ev.out_type    = EVT_ABS;
                case (step_reg)
                    STEP_W'(0): ev.out_code = CODE_MT_SLOT;
                    STEP_W'(1):
                    begin
                        ev.out_code  = CODE_MT_TRACK;
                        ev.out_value = 32'(head.track);
                    end
                    STEP_W'(2):
                    begin
                        ev.out_code  = CODE_MT_TOOL;
                        ev.out_value = TOOL_PEN;
                    end
                    STEP_W'(3):
                    begin
                        ev.out_code  = CODE_MT_POS_X;
                        ev.out_value = head.pos_x;
                    end
                    STEP_W'(4):
                    begin
                        ev.out_code  = CODE_MT_POS_Y;
                        ev.out_value = head.pos_y;
                    end
                    STEP_W'(5):
                    begin
                        ev.out_code  = CODE_MT_DIST;
                        ev.out_value = 32'(!head.contact);
                    end
                    STEP_W'(6):
                    begin
                        ev.out_type  = EVT_KEY;
                        ev.out_code  = B_TOUCH;
                        ev.out_value = 32'(head.contact);
                    end
                    STEP_W'(7):
                    begin
                        ev.out_code  = CODE_ABS_X;
                        ev.out_value = head.pos_x;
                    end
                    STEP_W'(8):
                    begin
                        ev.out_code  = CODE_ABS_Y;
                        ev.out_value = head.pos_y;
                    end
                    default:
                    begin
                        // closing sync
                        ev.out_type    = EVT_SYN;
                        ev.out_code    = SYNC_REPORT;
                        ev.last_of_run = 1'b1;
                    end
                endcase
            end
            CMD_FRAME_OFF:
            begin
                ev.last_of_run = 1'b0;
                case (step_reg)
                    STEP_W'(0):
                    begin
                        ev.out_type = EVT_ABS;
                        ev.out_code = CODE_MT_SLOT;
                    end
                    STEP_W'(1):
                    begin
                        ev.out_type  = EVT_ABS;
                        ev.out_code  = CODE_MT_TRACK;
                        ev.out_value = TRACK_RELEASE;
                    end
                    STEP_W'(2):
                    begin
                        ev.out_type = EVT_KEY;
                        ev.out_code = B_TOUCH;
                    end
                    default:
                    begin
                        ev.last_of_run = 1'b1;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= ev;
        end
    end

    // step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                res_valid_reg <= 1'b1;
                step_reg      <= ev.last_of_run ? '0 : step_reg + 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### design/tablet_to_multitouch_event_translator.sv
// ---------------------------------------------------------------------------
// tablet_to_multitouch_event_translator
// An input's first result beat passes the command queue and output register.
// One input beat per cycle while the queue has room; one result beat per
// cycle while res_ready is high. A frame flush is 10 beats (4 on release).
// The front keeps taking inputs while the 2-entry command queue has room.
// Reset: asynchronous, active low; clears pointer state, queue and output,
// the hover mode bit (hover_reg) returns to 1.
// ---------------------------------------------------------------------------
module tablet_to_multitouch_event_translator
    import ttm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data,
    input  logic evt_valid,
    output logic evt_ready,
    input  evt_t evt,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    logic cmd_push;
    cmd_t cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    cmd_t q_head;

    // input classification and pointer state
    ttm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .cmd_push  (cmd_push),
        .cmd       (cmd),
        .q_full    (q_full)
    );

    // command queue
    ttm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // event sequencer
    ttm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

### tb/tablet_to_multitouch_event_translator_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tablet_to_multitouch_event_translator_tb
// Drives tablet events into the translator and scores every multitouch beat
// it emits against an in-bench model of the translation or the expected
// beats in the table. A short table of hand-picked events runs first, then
// random tablet reports in both hover modes with random gaps and stalls.
// ---------------------------------------------------------------------------
module tablet_to_multitouch_event_translator_tb;
    import ttm_pkg::*;

    localparam int HALF_PERIOD_NS = 1;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_WAIT       = 17;
    localparam int PHASE_ITEMS    = 35;

    // one step of the directed plan; also carries random beats
    typedef struct packed {
        logic       is_cfg;
        logic       cfg_bit;
        logic       typed;
        logic [1:0] n_typed;
        evt_t       ev;
        res_t       r0;
        res_t       r1;
    } plan_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;
    logic      evt_valid = 1'b0;
    logic      evt_ready;
    evt_t      evt       = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    res_t      res;

    plan_row_t live_row  = '0;
    plan_row_t plan[$];
    res_t      frame_beats[$];
    res_t      expected_beats[$];
    bit        tx_calm   = 1'b0;
    bit        rx_calm   = 1'b0;
    int        error_count  = 0;
    int        stuck_cycles = 0;

    // translator model state
    logic        hover_mode = 1'b1;
    logic        ptr_active = 1'b0;
    logic        contact    = 1'b0;
    logic        was_active = 1'b0;
    logic        sync_owed  = 1'b0;
    logic        frame_owed = 1'b0;
    logic [15:0] track_id   = '0;
    logic [31:0] pen_x      = '0;
    logic [31:0] pen_y      = '0;

    tablet_to_multitouch_event_translator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // 2 ns clock
    always #(HALF_PERIOD_NS) clk = ~clk;

    function automatic res_t mk_res(input logic [15:0] t, input logic [15:0] c,
                                    input logic [31:0] v, input logic last);
        res_t r;
        r.out_type    = t;
        r.out_code    = c;
        r.out_value   = v;
        r.last_of_run = last;
        return r;
    endfunction

    function automatic plan_row_t evt_row(input logic [15:0] t, input logic [15:0] c,
                                          input logic [31:0] v);
        plan_row_t r;
        r = '0;
        r.ev.event_type  = t;
        r.ev.event_code  = c;
        r.ev.event_value = v;
        return r;
    endfunction

    function automatic plan_row_t typed_row(input logic [15:0] t, input logic [15:0] c,
                                            input logic [31:0] v, input logic [1:0] n,
                                            input res_t r0, input res_t r1);
        plan_row_t r;
        r         = evt_row(t, c, v);
        r.typed   = 1'b1;
        r.n_typed = n;
        r.r0      = r0;
        r.r1      = r1;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic b);
        plan_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.cfg_bit = b;
        return r;
    endfunction

    // values biased toward the edges of the 32-bit range
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return $urandom_range(0, 4095);
            default: return $urandom;
        endcase
    endfunction

    // translate one tablet event into the multitouch beats it should cause
    function automatic void translate_event(input evt_t e);
        logic [15:0] key;
        logic        pair;
        logic        known;
        logic [16:0] bumped;
        frame_beats.delete();
        key   = '0;
        pair  = 1'b0;
        known = 1'b1;
        if (hover_mode)
            ptr_active = 1'b1;
        else
            contact = 1'b1;
        case (e.event_type)
            EVT_KEY:
            begin
                if (e.event_code == B_LEFT)
                begin
                    if (hover_mode)
                        contact = (e.event_value != 0);
                    else
                        ptr_active = (e.event_value != 0);
                    frame_owed = 1'b1;
                end
                else
                begin
                    if (e.event_code == B_MIDDLE)
                        key = K_MENU;
                    else if (e.event_code == B_RIGHT)
                        key = K_BACK;
                    else if (e.event_code == B_GEAR_DOWN)
                    begin
                        key  = K_DOWN;
                        pair = 1'b1;
                    end
                    else if (e.event_code == B_GEAR_UP)
                    begin
                        key  = K_UP;
                        pair = 1'b1;
                    end
                    else
                        known = 1'b0;
                    if (known)
                    begin
                        if (pair)
                        begin
                            frame_beats.push_back(mk_res(EVT_KEY, key, 32'd1, 1'b0));
                            frame_beats.push_back(mk_res(EVT_KEY, key, 32'd0, 1'b0));
                        end
                        else
                            frame_beats.push_back(mk_res(EVT_KEY, key, e.event_value, 1'b0));
                        sync_owed = 1'b1;
                    end
                end
            end
            EVT_ABS:
            begin
                if (e.event_code == CODE_ABS_X)
                begin
                    pen_x      = e.event_value;
                    frame_owed = 1'b1;
                end
                else if (e.event_code == CODE_ABS_Y)
                begin
                    pen_y      = e.event_value;
                    frame_owed = 1'b1;
                end
            end
            EVT_SYN:
            begin
                if (e.event_code == SYNC_REPORT)
                begin
                    // flush the slot frame if one is owed, unless the pointer stayed inactive
                    if (frame_owed && (was_active || ptr_active))
                    begin
                        sync_owed = 1'b1;
                        frame_beats.push_back(mk_res(EVT_ABS, CODE_MT_SLOT, 32'd0, 1'b0));
                        if (ptr_active)
                        begin
                            frame_beats.push_back(mk_res(EVT_ABS, CODE_MT_TRACK,
                                                         {16'd0, track_id}, 1'b0));
                            frame_beats.push_back(mk_res(EVT_ABS, CODE_MT_TOOL, TOOL_PEN, 1'b0));
                            frame_beats.push_back(mk_res(EVT_ABS, CODE_MT_POS_X, pen_x, 1'b0));
                            frame_beats.push_back(mk_res(EVT_ABS, CODE_MT_POS_Y, pen_y, 1'b0));
                            frame_beats.push_back(mk_res(EVT_ABS, CODE_MT_DIST,
                                                         contact ? 32'd0 : 32'd1, 1'b0));
                            frame_beats.push_back(mk_res(EVT_KEY, B_TOUCH,
                                                         contact ? 32'd1 : 32'd0, 1'b0));
                            frame_beats.push_back(mk_res(EVT_ABS, CODE_ABS_X, pen_x, 1'b0));
                            frame_beats.push_back(mk_res(EVT_ABS, CODE_ABS_Y, pen_y, 1'b0));
                        end
                        else
                        begin
                            frame_beats.push_back(mk_res(EVT_ABS, CODE_MT_TRACK,
                                                         TRACK_RELEASE, 1'b0));
                            frame_beats.push_back(mk_res(EVT_KEY, B_TOUCH, 32'd0, 1'b0));
                            // tracking id advances and wraps past the maximum
                            bumped   = {1'b0, track_id} + 17'd1;
                            track_id = (bumped > TRACK_ID_MAX) ? 16'd0 : bumped[15:0];
                        end
                        frame_owed = 1'b0;
                        was_active = ptr_active;
                    end
                    if (sync_owed)
                    begin
                        frame_beats.push_back(mk_res(EVT_SYN, SYNC_REPORT, 32'd0, 1'b0));
                        sync_owed = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want_v);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want_v);
        error_count++;
    endtask

    // scoreboard and watchdog, sampled at each rising edge
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                hover_mode = cfg_data;
            if (evt_valid && evt_ready)
            begin
                translate_event(evt);
                if (live_row.typed)
                begin
                    if (live_row.n_typed > 0)
                        expected_beats.push_back(live_row.r0);
                    if (live_row.n_typed > 1)
                        expected_beats.push_back(live_row.r1);
                end
                else
                begin
                    for (int i = 0; i < frame_beats.size(); i++)
                    begin
                        want             = frame_beats[i];
                        want.last_of_run = (i == frame_beats.size() - 1);
                        expected_beats.push_back(want);
                    end
                end
            end
            if (res_valid && res_ready)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch("unexpected beat, code", 32'(res.out_code), 32'd0);
                else
                begin
                    want = expected_beats.pop_front();
                    if (res.out_type !== want.out_type)
                        report_mismatch("out_type", 32'(res.out_type), 32'(want.out_type));
                    if (res.out_code !== want.out_code)
                        report_mismatch("out_code", 32'(res.out_code), 32'(want.out_code));
                    if (res.out_value !== want.out_value)
                        report_mismatch("out_value", res.out_value, want.out_value);
                    if (res.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 32'(res.last_of_run),
                                        32'(want.last_of_run));
                end
            end
            if ((evt_valid && evt_ready) || (res_valid && res_ready) ||
                (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // result side: random stall before each beat, none while calm
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
        end
    end

    // send one event beat; valid stays up across back-to-back beats
    task automatic send_beat(input plan_row_t row);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt       <= row.ev;
        live_row  <= row;
        evt_valid <= 1'b1;
        do @(posedge clk); while (!evt_ready);
    endtask

    // let every expected beat drain, then give the back end time to go quiet
    task automatic wait_idle();
        evt_valid <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_hover(input logic b);
        wait_idle();
        cfg_data  <= b;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed tablet reports, some buttons, some junk
    task automatic send_random_items(input int count);
        int sent;
        int pick;
        logic [15:0] code;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    send_beat(evt_row(EVT_ABS, CODE_ABS_X, pick_value()));
                    sent++;
                end
                if ($urandom_range(0, 4) != 0)
                begin
                    send_beat(evt_row(EVT_ABS, CODE_ABS_Y, pick_value()));
                    sent++;
                end
                if ($urandom_range(0, 1) != 0)
                begin
                    send_beat(evt_row(EVT_KEY, B_LEFT,
                                      $urandom_range(0, 1) ? pick_value() : 32'd0));
                    sent++;
                end
                send_beat(evt_row(EVT_SYN, SYNC_REPORT, pick_value()));
                sent++;
            end
            else if (pick < 8)
            begin
                case ($urandom_range(0, 3))
                    0:       code = B_MIDDLE;
                    1:       code = B_RIGHT;
                    2:       code = B_GEAR_DOWN;
                    default: code = B_GEAR_UP;
                endcase
                send_beat(evt_row(EVT_KEY, code, pick_value()));
                sent++;
            end
            else if (pick == 8)
            begin
                send_beat(evt_row(16'($urandom), 16'($urandom), $urandom));
                sent++;
            end
            else
            begin
                // broken events of known types
                case ($urandom_range(0, 2))
                    0:       send_beat(evt_row(EVT_SYN, 16'($urandom_range(1, 65535)),
                                               $urandom));
                    1:       send_beat(evt_row(EVT_ABS, 16'($urandom_range(2, 65535)),
                                               $urandom));
                    default: send_beat(evt_row(EVT_KEY, 16'($urandom), $urandom));
                endcase
                sent++;
            end
        end
    endtask

    initial
    begin
        logic phase_hover;
        // directed plan, starting in hover mode after reset
        plan.push_back(typed_row(EVT_SYN, SYNC_REPORT, 32'd0, 2'd0, '0, '0));
        plan.push_back(typed_row(16'hFFFF, 16'hFFFF, 32'h8000_0000, 2'd0, '0, '0));
        plan.push_back(typed_row(EVT_KEY, B_MIDDLE, 32'h7FFF_FFFF, 2'd1,
                                 mk_res(EVT_KEY, K_MENU, 32'h7FFF_FFFF, 1'b1), '0));
        plan.push_back(typed_row(EVT_KEY, B_RIGHT, 32'h8000_0000, 2'd1,
                                 mk_res(EVT_KEY, K_BACK, 32'h8000_0000, 1'b1), '0));
        plan.push_back(typed_row(EVT_KEY, B_GEAR_DOWN, 32'd5, 2'd2,
                                 mk_res(EVT_KEY, K_DOWN, 32'd1, 1'b0),
                                 mk_res(EVT_KEY, K_DOWN, 32'd0, 1'b1)));
        plan.push_back(typed_row(EVT_KEY, B_GEAR_UP, 32'hFFFF_FFFF, 2'd2,
                                 mk_res(EVT_KEY, K_UP, 32'd1, 1'b0),
                                 mk_res(EVT_KEY, K_UP, 32'd0, 1'b1)));
        plan.push_back(typed_row(EVT_KEY, 16'hFFFF, 32'd1, 2'd0, '0, '0));
        plan.push_back(typed_row(EVT_ABS, 16'h0002, 32'd7, 2'd0, '0, '0));
        plan.push_back(typed_row(EVT_SYN, 16'h0001, 32'd0, 2'd0, '0, '0));
        plan.push_back(evt_row(EVT_ABS, CODE_ABS_X, 32'h7FFF_FFFF));
        plan.push_back(evt_row(EVT_ABS, CODE_ABS_Y, 32'h8000_0000));
        plan.push_back(evt_row(EVT_KEY, B_LEFT, 32'h0000_0100));
        plan.push_back(evt_row(EVT_SYN, SYNC_REPORT, 32'd0));
        plan.push_back(evt_row(EVT_KEY, B_LEFT, 32'd0));
        plan.push_back(evt_row(EVT_SYN, SYNC_REPORT, 32'hFFFF_FFFF));
        // button now drives the active flag
        plan.push_back(cfg_row(1'b0));
        plan.push_back(evt_row(EVT_KEY, B_LEFT, 32'd0));
        plan.push_back(evt_row(EVT_SYN, SYNC_REPORT, 32'd0));
        plan.push_back(evt_row(EVT_ABS, CODE_ABS_X, 32'd0));
        // inactive twice: no frame and no sync
        plan.push_back(typed_row(EVT_SYN, SYNC_REPORT, 32'd0, 2'd0, '0, '0));
        plan.push_back(evt_row(EVT_KEY, B_LEFT, 32'hFFFF_FFFF));
        plan.push_back(evt_row(EVT_SYN, SYNC_REPORT, 32'd0));
        plan.push_back(evt_row(EVT_KEY, B_GEAR_UP, 32'd0));
        plan.push_back(typed_row(EVT_SYN, SYNC_REPORT, 32'd0, 2'd1,
                                 mk_res(EVT_SYN, SYNC_REPORT, 32'd0, 1'b1), '0));
        plan.push_back(cfg_row(1'b1));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_hover(plan[i].cfg_bit);
            else
                send_beat(plan[i]);
        end

        // random phases across both modes, one of them without idling
        for (int phase = 0; phase < 6; phase++)
        begin
            phase_hover = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
            write_hover(phase_hover);
            tx_calm = (phase == 3);
            rx_calm = (phase == 3) || (phase == 4);
            if (phase == 2)
            begin
                // sender holds off until the block has drained
                send_random_items(PHASE_ITEMS / 2);
                wait_idle();
                send_random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
            end
            else
                send_random_items(PHASE_ITEMS);
        end

        wait_idle();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
